[src/dtps_pkg.sv]
package dtps_pkg;

	// number of ranked candidates held in the cell chain
	localparam int RANKS = 3;

	// default number of arrival positions per event
	localparam int MAX_JETS_DEF = 256;

	localparam int MOM_W = 16;
	localparam int POS_W = 8;
	localparam int FIRED_W = 2;
	localparam int CFG_DW = 32;
	localparam int CFG_AW = 3;

	// register indexes, taken from paddr[2]
	localparam logic REG_TRIGGER = 1'b0;
	localparam logic REG_MINIMUM = 1'b1;

	// fired count codes
	localparam logic [FIRED_W-1:0] FIRED_NONE = 2'd0;
	localparam logic [FIRED_W-1:0] FIRED_ONE  = 2'd1;
	localparam logic [FIRED_W-1:0] FIRED_TWO  = 2'd2;
	localparam logic [FIRED_W-1:0] FIRED_MANY = 2'd3;

	// one ranked candidate
	typedef struct packed {
		logic             valid;
		logic [MOM_W-1:0] mom;
		logic [POS_W-1:0] pos;
	} cell_t;

	// one result word, lowest field in the lowest bits
	typedef struct packed {
		logic [1:0]         pad;
		logic               position_overflow;
		logic [FIRED_W-1:0] fired_count;
		logic [POS_W-1:0]   sublead_probe_position;
		logic               sublead_probe_valid;
		logic [POS_W-1:0]   lead_probe_position;
		logic               lead_probe_valid;
		logic [POS_W-1:0]   tag_position;
		logic               tag_valid;
	} result_t;

endpackage

[src/dtps_rank_cell.sv]
module dtps_rank_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ins_en,
	input  logic                clear,
	input  logic [15:0]         jet_mom,
	input  logic [7:0]          jet_pos,
	input  dtps_pkg::cell_t     prev_q,
	input  logic                prev_cond,
	output dtps_pkg::cell_t     cell_q,
	output dtps_pkg::cell_t     cell_nxt,
	output logic                cond
);
	import dtps_pkg::*;

	// the new jet belongs at or above this cell; ties keep the older jet
	assign cond = !cell_q.valid || (jet_mom > cell_q.mom);

	// shift from the neighbor, take the new jet, or hold
	always_comb begin
		cell_nxt = cell_q;
		if (ins_en) begin
			if (prev_cond) begin
				cell_nxt = prev_q;
			end else if (cond) begin
				cell_nxt.valid = 1'b1;
				cell_nxt.mom   = jet_mom;
				cell_nxt.pos   = jet_pos;
			end
		end
	end

	// drop the candidate at the end of each event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (clear) begin
			cell_q <= '0;
		end else begin
			cell_q <= cell_nxt;
		end
	end

endmodule

[src/dtps_chooser.sv]
module dtps_chooser (
	input  dtps_pkg::cell_t       cells [dtps_pkg::RANKS],
	input  logic [1:0]            fired,
	input  logic                  enough_jets,
	input  logic                  overflow,
	output dtps_pkg::result_t     res
);
	import dtps_pkg::*;

	// map ranks onto tag and probes by fired count
	always_comb begin
		res = '0;
		res.fired_count       = fired;
		res.position_overflow = overflow;
		if (enough_jets) begin
			case (fired)
				FIRED_NONE: begin
				end
				FIRED_ONE: begin
					res.tag_valid           = cells[0].valid;
					res.sublead_probe_valid = cells[1].valid;
				end
				FIRED_TWO: begin
					res.lead_probe_valid = cells[0].valid;
					res.tag_valid        = cells[1].valid;
				end
				FIRED_MANY: begin
					res.lead_probe_valid    = cells[0].valid;
					res.sublead_probe_valid = cells[1].valid;
					res.tag_valid           = cells[2].valid;
				end
				default: begin
				end
			endcase
		end
		// positions of unchosen outputs read zero
		if (res.tag_valid) begin
			case (fired)
				FIRED_ONE:  res.tag_position = cells[0].pos;
				FIRED_TWO:  res.tag_position = cells[1].pos;
				default:    res.tag_position = cells[2].pos;
			endcase
		end
		if (res.lead_probe_valid) begin
			res.lead_probe_position = cells[0].pos;
		end
		if (res.sublead_probe_valid) begin
			res.sublead_probe_position = cells[1].pos;
		end
	end

endmodule

[src/dijet_tag_probe_selector.sv]
// Channel  | Direction | Handshake             | Payload
// s_axis   | in        | tvalid/tready         | tdata: jet_momentum[15:0]; tlast: last_jet
// m_axis   | out       | tvalid/tready         | tdata: one result word, 30 bits used
// apb      | config    | psel/penable, pready  | 0x0 trigger_threshold, 0x4 minimum_threshold
//
// One jet is taken per cycle while s_axis_tready is high; three rank cells insert it in
// that cycle if above minimum_threshold, within MAX_JETS. An event's result is registered
// on the edge taking its last jet, shows on m_axis the next cycle; cells clear on that edge.
// s_axis_tready drops only while a result waits and m_axis_tready is low.
// arst_n clears thresholds, cells, counters and the output register.
module dijet_tag_probe_selector #(
	parameter int MAX_JETS = dtps_pkg::MAX_JETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [15:0]                s_axis_tdata,   // jet_momentum[15:0]
	input  logic                       s_axis_tlast,   // last_jet
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// tag_valid[0], tag_position[8:1], lead_probe_valid[9], lead_probe_position[17:10],
	// sublead_probe_valid[18], sublead_probe_position[26:19], fired_count[28:27],
	// position_overflow[29], zero[31:30]
	output logic [31:0]                m_axis_tdata,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dtps_pkg::CFG_AW-1:0] paddr,
	input  logic [dtps_pkg::CFG_DW-1:0] pwdata,
	output logic [dtps_pkg::CFG_DW-1:0] prdata,
	output logic                       pready
);
	import dtps_pkg::*;

	localparam int CNT_W = $clog2(MAX_JETS + 2);

	logic [MOM_W-1:0]   trigger_q;
	logic [MOM_W-1:0]   minimum_q;
	logic [CNT_W-1:0]   seen_q;
	logic [CNT_W-1:0]   seen_nxt;
	logic [FIRED_W-1:0] fired_q;
	logic [FIRED_W-1:0] fired_nxt;
	logic               in_acc;
	logic               room;
	logic               keep;
	logic               ins_en;
	logic               clear;
	logic [POS_W-1:0]   jet_pos;
	cell_t              cell_q   [RANKS];
	cell_t              cell_nxt [RANKS];
	logic               cond     [RANKS];
	result_t            res;
	result_t            out_q;
	logic               out_valid_q;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MINIMUM) ? CFG_DW'(minimum_q) : CFG_DW'(trigger_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= '0;
			minimum_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_TRIGGER) begin
				trigger_q <= pwdata[MOM_W-1:0];
			end else begin
				minimum_q <= pwdata[MOM_W-1:0];
			end
		end
	end

	// take a word whenever the output register is free or draining
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign room          = seen_q < CNT_W'(MAX_JETS);
	assign keep          = s_axis_tdata > minimum_q;
	assign ins_en        = in_acc && room && keep;
	assign clear         = in_acc && s_axis_tlast;
	assign jet_pos       = POS_W'(seen_q);

	// advance the jet counter and fired count
	always_comb begin
		seen_nxt  = seen_q;
		fired_nxt = fired_q;
		if (in_acc) begin
			if (room) begin
				seen_nxt = seen_q + CNT_W'(1);
			end else begin
				seen_nxt = CNT_W'(MAX_JETS + 1);
			end
		end
		if (ins_en && (s_axis_tdata > trigger_q) && (fired_q != FIRED_MANY)) begin
			fired_nxt = fired_q + FIRED_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			fired_q <= '0;
		end else if (clear) begin
			seen_q  <= '0;
			fired_q <= '0;
		end else begin
			seen_q  <= seen_nxt;
			fired_q <= fired_nxt;
		end
	end

	// rank cell chain, highest momentum in cell 0
	for (genvar i = 0; i < RANKS; i++) begin : g_cell
		cell_t prev_q;
		logic  prev_cond;
		if (i == 0) begin : g_head
			assign prev_q    = '0;
			assign prev_cond = 1'b0;
		end else begin : g_body
			assign prev_q    = cell_q[i-1];
			assign prev_cond = cond[i-1];
		end
		dtps_rank_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ins_en    (ins_en),
			.clear     (clear),
			.jet_mom   (s_axis_tdata),
			.jet_pos   (jet_pos),
			.prev_q    (prev_q),
			.prev_cond (prev_cond),
			.cell_q    (cell_q[i]),
			.cell_nxt  (cell_nxt[i]),
			.cond      (cond[i])
		);
	end

	// choose tag and probes from the updated event state
	dtps_chooser u_chooser (
		.cells       (cell_nxt),
		.fired       (fired_nxt),
		.enough_jets (seen_nxt >= CNT_W'(2)),
		.overflow    (seen_nxt > CNT_W'(MAX_JETS)),
		.res         (res)
	);

	// hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (clear) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (clear) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule
